FILE: src/pts_pkg.sv
// Shared types and codes of the priority thread scheduler.
// Request and result payload structs, request and status codes.
// No dependencies.
package pts_pkg;

	// Configuration data width (idle thread priority register)
	localparam int CFG_W = 8;

	// Request codes
	localparam logic [2:0] REQ_INIT   = 3'd0;
	localparam logic [2:0] REQ_START  = 3'd1;
	localparam logic [2:0] REQ_STATUS = 3'd2;
	localparam logic [2:0] REQ_EXIT   = 3'd3;
	localparam logic [2:0] REQ_SCHED  = 3'd4;

	// Thread status codes
	localparam logic [1:0] ST_CREATING = 2'd0;
	localparam logic [1:0] ST_RUNNING  = 2'd1;
	localparam logic [1:0] ST_BLOCKED  = 2'd2;
	localparam logic [1:0] ST_DETACHED = 2'd3;

	// Result codes
	localparam logic RES_OK        = 1'b0;
	localparam logic RES_BAD_PARAM = 1'b1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] thread_slot;
		logic [7:0] new_priority;
		logic [1:0] set_status;
		logic       params_ok;
	} req_t;

	typedef struct packed {
		logic       result_code;
		logic [3:0] next_slot;
		logic       any_running;
		logic       switched;
		logic [3:0] current_slot;
		logic       current_valid;
	} res_t;

endpackage

FILE: src/priority_thread_scheduler_unit.sv
// Requests are handled one at a time, each passing the check, walk, wrap and finish states
// in order. The walk goes over the order list, which holds the started slots (at most
// MAX_THREADS), one entry per cycle, each entry reading the order-list memory and then the
// slot-table memory. The result sits in an output register and the next request is taken
// while it waits; a result still stalled there when the next one finishes holds the block
// in its finish state until the register is free.
// No clearing pass follows reset: the slot table carries one valid bit per entry. Slot 0
// becomes the idle thread on the first schedule, with the priority held in the
// configuration register (reset value 255).
//
// Top level of the scheduler: slot table, order list, request sequencer.
// Depends on pts_pkg.
module priority_thread_scheduler_unit #(
	parameter int MAX_THREADS   = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  pts_pkg::req_t             in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output pts_pkg::res_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pts_pkg::CFG_W-1:0] cfg_data
);
	import pts_pkg::*;

	localparam int SLOT_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int LEN_W  = $clog2(MAX_THREADS + 1);

	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [1:0]               status;
		logic                     listed;
	} slot_ent_t;

	typedef enum logic [4:0] {
		FSM_IDLE  = 5'b00001,
		FSM_CHECK = 5'b00010,
		FSM_WALK  = 5'b00100,
		FSM_WRAP  = 5'b01000,
		FSM_FIN   = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         idle_prio_q;

	// request context
	req_t                     req_q;
	logic [SLOT_W-1:0]        tgt_q;
	logic                     tgt_ok_q;
	logic [SLOT_W-1:0]        tgt_in;
	logic                     tgt_ok_in;

	// slot table memory
	slot_ent_t                slot_mem [MAX_THREADS];
	logic [MAX_THREADS-1:0]   slot_vld_q;
	slot_ent_t                slot_rd_q;
	logic                     slot_rd_vld_q;
	slot_ent_t                ent;
	logic [SLOT_W-1:0]        slot_raddr;
	logic                     slot_we;
	slot_ent_t                slot_wdata;

	// order list memory
	logic [SLOT_W-1:0]        list_mem [MAX_THREADS];
	logic [SLOT_W-1:0]        list_rd_s1;
	logic                     list_we;
	logic [SLOT_W-1:0]        list_waddr;
	logic [SLOT_W-1:0]        list_wdata;

	// architectural state
	logic [LEN_W-1:0]         len_q;
	logic [SLOT_W-1:0]        cur_q;
	logic                     present_q;

	// list walk
	logic [LEN_W-1:0]         rd_idx_q;
	logic [LEN_W-1:0]         wr_idx_q;
	logic                     v_s1_q;
	logic                     v_s2_q;
	logic [SLOT_W-1:0]        e_s2;
	logic                     rebuild_q;
	logic [PRIORITY_BITS-1:0] ps_q;
	logic                     inserted_q;
	logic [SLOT_W-1:0]        pend_q;
	logic                     found_q;
	logic [SLOT_W-1:0]        next_q;
	logic                     code_q;
	logic                     sw_q;

	logic                     issue;
	logic                     walk_done;
	logic                     s2_act;
	logic                     s2_self;
	logic                     s2_ins;
	logic                     s2_shift;
	logic                     s2_copy;
	logic                     s2_run;
	logic                     start_ok;
	logic                     first_sched;
	logic                     found_f;
	logic [SLOT_W-1:0]        next_f;

	logic                     out_valid_q;
	res_t                     out_data_q;
	logic                     out_free;

	assign in_stall  = (state_q != FSM_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Target slot of an incoming request
	always_comb begin
		tgt_in    = SLOT_W'(in_data.thread_slot);
		tgt_ok_in = (32'(in_data.thread_slot) < 32'(MAX_THREADS));
		unique case (in_data.req_type)
			REQ_EXIT: begin
				tgt_in    = cur_q;
				tgt_ok_in = 1'b1;
			end
			REQ_SCHED: begin
				tgt_in    = '0;
				tgt_ok_in = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Slot table read data; never-written entries read as reset value
	assign ent        = slot_rd_vld_q ? slot_rd_q : slot_ent_t'('0);
	assign slot_raddr = (state_q == FSM_IDLE) ? tgt_in : list_rd_s1;

	assign start_ok    = tgt_ok_q && (ent.status == ST_CREATING) && req_q.params_ok;
	assign first_sched = (req_q.req_type == REQ_SCHED) && !present_q;

	// Slot table update in the check step
	always_comb begin
		slot_we    = 1'b0;
		slot_wdata = ent;
		if (state_q == FSM_CHECK) begin
			unique case (req_q.req_type)
				REQ_INIT: begin
					slot_we    = tgt_ok_q;
					slot_wdata = '{prio: PRIORITY_BITS'(req_q.new_priority),
						status: ST_CREATING, listed: ent.listed};
				end
				REQ_START: begin
					slot_we    = start_ok;
					slot_wdata = '{prio: ent.prio, status: ST_RUNNING, listed: 1'b1};
				end
				REQ_STATUS: begin
					slot_we    = tgt_ok_q;
					slot_wdata = '{prio: ent.prio, status: req_q.set_status,
						listed: ent.listed};
				end
				REQ_EXIT: begin
					slot_we    = present_q;
					slot_wdata = '{prio: ent.prio, status: ST_DETACHED, listed: ent.listed};
				end
				REQ_SCHED: begin
					slot_we    = !present_q;
					slot_wdata = '{prio: PRIORITY_BITS'(idle_prio_q), status: ST_RUNNING,
						listed: 1'b1};
				end
				default: begin
				end
			endcase
		end
	end

	// Walk control: issue one list read per cycle, two-stage read chain
	assign issue     = (state_q == FSM_WALK) && (rd_idx_q < len_q);
	assign walk_done = (state_q == FSM_WALK) && !issue && !v_s1_q && !v_s2_q;

	// Per-entry decisions at the end of the read chain
	assign s2_act   = (state_q == FSM_WALK) && v_s2_q;
	assign s2_self  = rebuild_q && (e_s2 == tgt_q);
	assign s2_ins   = rebuild_q && !s2_self && !inserted_q && (ps_q <= ent.prio);
	assign s2_shift = rebuild_q && !s2_self && inserted_q;
	assign s2_copy  = rebuild_q && !s2_self && !inserted_q && !s2_ins;
	assign s2_run   = !s2_self && !inserted_q && !s2_ins && (ent.status == ST_RUNNING);

	// Final pick: a rebuilt list always holds the running target slot
	assign found_f = found_q || rebuild_q;
	assign next_f  = found_q ? next_q : (rebuild_q ? tgt_q : '0);

	// Order list write port: rewrite in place, lagging the reads
	always_comb begin
		list_we    = 1'b0;
		list_waddr = wr_idx_q[SLOT_W-1:0];
		list_wdata = tgt_q;
		priority if (state_q == FSM_WRAP) begin
			list_we    = rebuild_q;
			list_wdata = inserted_q ? pend_q : tgt_q;
		end else if (s2_act) begin
			priority if (s2_ins) begin
				list_we    = 1'b1;
				list_wdata = tgt_q;
			end else if (s2_shift) begin
				list_we    = 1'b1;
				list_wdata = pend_q;
			end else if (s2_copy) begin
				list_we    = 1'b1;
				list_wdata = e_s2;
			end else begin
				// old entry of the moved slot, or a plain search: no write
			end
		end else begin
			// no list write this cycle
		end
	end

	// Memories
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[tgt_q] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		list_rd_s1 <= list_mem[rd_idx_q[SLOT_W-1:0]];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			idle_prio_q   <= '1;
			slot_vld_q    <= '0;
			slot_rd_vld_q <= 1'b0;
			len_q         <= '0;
			cur_q         <= '0;
			present_q     <= 1'b0;
			v_s1_q        <= 1'b0;
			v_s2_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				idle_prio_q <= cfg_data;
			end
			if (slot_we) begin
				slot_vld_q[tgt_q] <= 1'b1;
			end
			slot_rd_vld_q <= slot_vld_q[slot_raddr];
			v_s1_q        <= issue;
			v_s2_q        <= v_s1_q && (state_q == FSM_WALK);

			// output register: load on finish, drop on transfer
			if ((state_q == FSM_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				FSM_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= FSM_CHECK;
					end
				end
				FSM_CHECK: begin
					if (first_sched) begin
						cur_q     <= '0;
						present_q <= 1'b1;
					end
					state_q <= FSM_WALK;
				end
				FSM_WALK: begin
					if (walk_done) begin
						state_q <= FSM_WRAP;
					end
				end
				FSM_WRAP: begin
					if (rebuild_q) begin
						len_q <= LEN_W'(wr_idx_q + 1'b1);
					end
					if ((req_q.req_type == REQ_SCHED) && found_f && (next_f != cur_q)) begin
						cur_q <= next_f;
					end
					state_q <= FSM_FIN;
				end
				FSM_FIN: begin
					if (out_free) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		e_s2 <= list_rd_s1;
		if (issue) begin
			rd_idx_q <= LEN_W'(rd_idx_q + 1'b1);
		end

		if (state_q == FSM_IDLE) begin
			req_q    <= in_data;
			tgt_q    <= tgt_in;
			tgt_ok_q <= tgt_ok_in;
		end

		if (state_q == FSM_CHECK) begin
			code_q     <= (req_q.req_type == REQ_START) && !start_ok;
			rebuild_q  <= ((req_q.req_type == REQ_START) && start_ok) || first_sched;
			ps_q       <= first_sched ? PRIORITY_BITS'(idle_prio_q) : ent.prio;
			sw_q       <= first_sched;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			inserted_q <= 1'b0;
			found_q    <= 1'b0;
			next_q     <= '0;
		end

		// per-entry bookkeeping
		if (s2_act) begin
			if (s2_ins) begin
				inserted_q <= 1'b1;
				pend_q     <= e_s2;
				wr_idx_q   <= LEN_W'(wr_idx_q + 1'b1);
				if (!found_q) begin
					found_q <= 1'b1;
					next_q  <= tgt_q;
				end
			end else if (s2_shift) begin
				pend_q   <= e_s2;
				wr_idx_q <= LEN_W'(wr_idx_q + 1'b1);
			end else begin
				if (s2_copy) begin
					wr_idx_q <= LEN_W'(wr_idx_q + 1'b1);
				end
				if (!found_q && s2_run) begin
					found_q <= 1'b1;
					next_q  <= e_s2;
				end
			end
		end

		if (state_q == FSM_WRAP) begin
			found_q <= found_f;
			next_q  <= next_f;
			if ((req_q.req_type == REQ_SCHED) && found_f && (next_f != cur_q)) begin
				sw_q <= 1'b1;
			end
		end

		if ((state_q == FSM_FIN) && out_free) begin
			out_data_q.result_code   <= code_q ? RES_BAD_PARAM : RES_OK;
			out_data_q.next_slot     <= 4'(next_q);
			out_data_q.any_running   <= found_q;
			out_data_q.switched      <= sw_q;
			out_data_q.current_slot  <= 4'(cur_q);
			out_data_q.current_valid <= present_q;
		end
	end

endmodule

FILE: src/pts_checker.sv
// Port-level checker for the priority thread scheduler, bound to the top level.
// Depends on pts_pkg and priority_thread_scheduler_unit.
module pts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input pts_pkg::res_t out_data
);
	import pts_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one request at a time: a transfer in makes the block busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request transfer");

	// a new result only comes from a request in progress
	a_out_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in progress");

	// a switch always lands on the picked running thread
	a_switch_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.switched |-> out_data.current_valid &&
			out_data.any_running && (out_data.current_slot == out_data.next_slot))
		else $error("switch did not land on the next running thread");

endmodule

bind priority_thread_scheduler_unit pts_checker u_pts_checker (.*);

FILE: verif/priority_thread_scheduler_unit_test.sv
// Self-checking testbench for priority_thread_scheduler_unit: directed and random requests
// checked against an in-bench scheduler model held in a small scoreboard class.
// Depends on pts_pkg and priority_thread_scheduler_unit.
module priority_thread_scheduler_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pts_pkg::*;

	localparam int MAX_SLOTS = 16;
	localparam int HANG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam logic [2:0] REQ_UNUSED_TOP = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	res_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	bit quiet_tail;
	int quiet_cycles;

	// Scheduler model and queue of expected results
	class sched_scoreboard;
		bit [7:0] thread_prio[MAX_SLOTS];
		bit [1:0] thread_state[MAX_SLOTS];
		bit in_order[MAX_SLOTS];
		bit [3:0] run_order[MAX_SLOTS];
		int run_count;
		bit [3:0] active_slot;
		bit active_known;
		bit [7:0] idle_prio;
		res_t expected_results[$];
		int mismatches;

		function new();
			run_count = 0;
			active_slot = '0;
			active_known = 1'b0;
			idle_prio = 8'hFF;
			mismatches = 0;
		endfunction

		function void set_idle_priority(bit [7:0] value);
			idle_prio = value;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function void remove_from_order(bit [3:0] s);
			int kept;
			kept = 0;
			for (int i = 0; i < run_count; i++) begin
				if (run_order[i] != s) begin
					run_order[kept] = run_order[i];
					kept++;
				end
			end
			run_count = kept;
			in_order[s] = 1'b0;
		endfunction

		// Lower value first; ties go behind nothing, so the newest start leads its group
		function void insert_by_priority(bit [3:0] s);
			int pos;
			if (in_order[s])
				remove_from_order(s);
			pos = 0;
			while (pos < run_count && thread_prio[s] > thread_prio[run_order[pos]])
				pos++;
			if (run_count >= MAX_SLOTS)
				return;
			for (int i = run_count; i > pos; i--)
				run_order[i] = run_order[i - 1];
			run_order[pos] = s;
			run_count++;
			in_order[s] = 1'b1;
		endfunction

		function bit start_slot(bit [3:0] s, bit ok);
			if (thread_state[s] != ST_CREATING || !ok)
				return RES_BAD_PARAM;
			insert_by_priority(s);
			thread_state[s] = ST_RUNNING;
			return RES_OK;
		endfunction

		function bit find_runnable(output bit [3:0] s);
			s = '0;
			for (int i = 0; i < run_count; i++) begin
				if (thread_state[run_order[i]] == ST_RUNNING) begin
					s = run_order[i];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Apply one accepted request and queue the result it must produce
		function void note_request(req_t r);
			res_t want;
			bit [3:0] pick;
			bit found;
			want = '0;
			case (r.req_type)
				REQ_INIT: begin
					thread_prio[r.thread_slot] = r.new_priority;
					thread_state[r.thread_slot] = ST_CREATING;
				end
				REQ_START: want.result_code = start_slot(r.thread_slot, r.params_ok);
				REQ_STATUS: thread_state[r.thread_slot] = r.set_status;
				REQ_EXIT: begin
					if (active_known)
						thread_state[active_slot] = ST_DETACHED;
				end
				REQ_SCHED: begin
					// first schedule brings up the idle thread in slot 0
					if (!active_known) begin
						thread_prio[0] = idle_prio;
						thread_state[0] = ST_CREATING;
						void'(start_slot(4'd0, 1'b1));
						active_slot = 4'd0;
						active_known = 1'b1;
						want.switched = 1'b1;
					end
					found = find_runnable(pick);
					if (found && pick != active_slot) begin
						active_slot = pick;
						want.switched = 1'b1;
					end
				end
				default: ;
			endcase
			found = find_runnable(pick);
			want.next_slot = pick;
			want.any_running = found;
			want.current_slot = active_slot;
			want.current_valid = active_known;
			expected_results.push_back(want);
		endfunction

		function void check_result(res_t got);
			res_t want;
			string bad;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result with nothing expected:", $realtime);
					$display("  actual   code=%0d next=%0d any=%0d sw=%0d cur=%0d curv=%0d",
						got.result_code, got.next_slot, got.any_running, got.switched,
						got.current_slot, got.current_valid);
				end
				return;
			end
			want = expected_results.pop_front();
			bad = "";
			if (got.result_code !== want.result_code) bad = {bad, " result_code"};
			if (got.next_slot !== want.next_slot) bad = {bad, " next_slot"};
			if (got.any_running !== want.any_running) bad = {bad, " any_running"};
			if (got.switched !== want.switched) bad = {bad, " switched"};
			if (got.current_slot !== want.current_slot) bad = {bad, " current_slot"};
			if (got.current_valid !== want.current_valid) bad = {bad, " current_valid"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch in%s", $realtime, bad);
					$display("  expected code=%0d next=%0d any=%0d sw=%0d cur=%0d curv=%0d",
						want.result_code, want.next_slot, want.any_running, want.switched,
						want.current_slot, want.current_valid);
					$display("  actual   code=%0d next=%0d any=%0d sw=%0d cur=%0d curv=%0d",
						got.result_code, got.next_slot, got.any_running, got.switched,
						got.current_slot, got.current_valid);
				end
			end
		endfunction
	endclass

	sched_scoreboard board;

	priority_thread_scheduler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result-side backpressure in short random bursts
	initial begin : stall_gen
		int burst;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 5);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Transfer monitor and hang watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_request(in_data);
			if (out_valid && !out_stall)
				board.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("priority_thread_scheduler_unit test failed");
				$finish;
			end
		end
	end

	function automatic req_t build_req(logic [2:0] kind, logic [3:0] slot, logic [7:0] prio,
			logic [1:0] state, logic ok);
		req_t r;
		r.req_type = kind;
		r.thread_slot = slot;
		r.new_priority = prio;
		r.set_status = state;
		r.params_ok = ok;
		return r;
	endfunction

	// Random content; priorities often collide so equal-priority ordering is exercised
	function automatic req_t random_req(logic [2:0] kind);
		req_t r;
		r.req_type = kind;
		r.thread_slot = 4'($urandom_range(0, MAX_SLOTS - 1));
		if ($urandom_range(0, 1) != 0)
			r.new_priority = 8'($urandom_range(0, 255));
		else
			r.new_priority = 8'($urandom_range(0, 3));
		if ($urandom_range(0, 1) != 0)
			r.set_status = ST_RUNNING;
		else
			r.set_status = 2'($urandom_range(0, 3));
		r.params_ok = ($urandom_range(0, 7) != 0);
		return r;
	endfunction

	// Holds valid until the transfer; valid stays high unless a gap comes next
	task automatic send_request(req_t r);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Register writes only with the block drained
	task automatic write_idle_priority(logic [7:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (MAX_SLOTS + 8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.set_idle_priority(value);
	endtask

	task automatic run_random(int count);
		int sent;
		int pick;
		req_t r;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// init followed by a start of the same slot
				r = random_req(REQ_INIT);
				send_request(r);
				r.req_type = REQ_START;
				r.params_ok = ($urandom_range(0, 7) != 0);
				send_request(r);
				sent += 2;
			end else begin
				if (pick < 50)
					r = random_req(REQ_STATUS);
				else if (pick < 60)
					r = random_req(REQ_EXIT);
				else if (pick < 85)
					r = random_req(REQ_SCHED);
				else if (pick < 92)
					r = random_req(REQ_START);
				else if (pick < 97)
					r = random_req(REQ_INIT);
				else
					r = random_req(3'($urandom_range(REQ_SCHED + 1, REQ_UNUSED_TOP)));
				send_request(r);
				sent++;
			end
		end
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		quiet_tail = 1'b0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// List building before any thread is current
		write_idle_priority(8'hFF);
		send_request(build_req(REQ_EXIT, 4'd0, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_INIT, 4'd5, 8'h80, ST_CREATING, 1'b0));
		send_request(build_req(REQ_START, 4'd5, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_START, 4'd5, 8'h00, ST_CREATING, 1'b1));
		send_request(build_req(REQ_START, 4'd5, 8'h00, ST_CREATING, 1'b1));
		send_request(build_req(REQ_INIT, 4'd15, 8'h00, ST_CREATING, 1'b1));
		send_request(build_req(REQ_START, 4'd15, 8'h00, ST_CREATING, 1'b1));
		send_request(build_req(REQ_INIT, 4'd10, 8'hFF, ST_DETACHED, 1'b1));
		send_request(build_req(REQ_START, 4'd10, 8'hFF, ST_DETACHED, 1'b1));
		send_request(build_req(REQ_INIT, 4'd7, 8'h80, ST_CREATING, 1'b0));
		send_request(build_req(REQ_START, 4'd7, 8'h00, ST_CREATING, 1'b1));
		send_request(build_req(REQ_STATUS, 4'd15, 8'h00, ST_BLOCKED, 1'b0));
		// re-init of a listed slot, then restart moves its entry
		send_request(build_req(REQ_INIT, 4'd5, 8'h01, ST_RUNNING, 1'b1));
		send_request(build_req(REQ_START, 4'd5, 8'h01, ST_CREATING, 1'b1));
		send_request(build_req(REQ_UNUSED_TOP, 4'd9, 8'hAA, ST_RUNNING, 1'b1));

		// First schedule with the most urgent idle priority, then switching and exit
		write_idle_priority(8'h00);
		send_request(build_req(REQ_SCHED, 4'd0, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_STATUS, 4'd0, 8'h00, ST_BLOCKED, 1'b0));
		send_request(build_req(REQ_SCHED, 4'd0, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_EXIT, 4'd0, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_SCHED, 4'd0, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_STATUS, 4'd15, 8'h00, ST_RUNNING, 1'b0));
		send_request(build_req(REQ_STATUS, 4'd10, 8'h00, ST_DETACHED, 1'b0));
		send_request(build_req(REQ_SCHED, 4'd0, 8'h00, ST_CREATING, 1'b0));
		send_request(build_req(REQ_INIT, 4'd0, 8'h55, ST_CREATING, 1'b0));
		send_request(build_req(REQ_START, 4'd0, 8'h55, ST_CREATING, 1'b1));

		// Random traffic across several register settings
		write_idle_priority(8'($urandom_range(0, 255)));
		run_random(450);
		write_idle_priority(8'hFF);
		run_random(450);
		write_idle_priority(8'($urandom_range(0, 255)));
		run_random(450);
		write_idle_priority(8'h00);
		quiet_tail = 1'b1;
		run_random(400);
		in_valid <= 1'b0;
		@(posedge clk);

		// Drain and settle
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("priority_thread_scheduler_unit test passed");
		else
			$display("priority_thread_scheduler_unit test failed");
		$finish;
	end

endmodule

FILE: files.f
src/pts_pkg.sv
src/priority_thread_scheduler_unit.sv
src/pts_checker.sv
verif/priority_thread_scheduler_unit_test.sv
